>>> rtl/assert_macros.svh
// assertion macros for the quaternion to euler rtl
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define QTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define QTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/qte_pkg.sv
// constants, types and angle helpers for the quaternion to euler pipeline
// no dependencies; imported by qte_cordic, qte_isqrt and the top level
package qte_pkg;

  // cordic configuration
  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int ATAN_ENTRIES  = 24;

  // datapath widths
  localparam int XW          = 36;  // cordic x/y, headroom for gain and prerotation
  localparam int SP_W        = 30;  // saturated sin(pitch), q28
  localparam int ROOT_W      = 29;  // cos(pitch), q28, up to 2^28
  localparam int RAD_W       = 57;  // radicand 2^56 - sp^2
  localparam int SQ_NW       = 58;  // isqrt working width
  localparam int SQRT_STAGES = ROOT_W;

  // latencies in cycles
  localparam int CORDIC_LAT = CORDIC_STAGES + 2;
  localparam int HB_DLY     = 1 + SQRT_STAGES;
  localparam int PIPE_LAT   = 4 + SQRT_STAGES + CORDIC_LAT;

  // fixed-point constants
  localparam logic [28:0] LOCK_LIMIT = 29'd268408612;
  localparam logic signed [SP_W-1:0] SP_ONE = 30'sd268435456;
  localparam logic signed [33:0] HALF_Q28 = 34'sd134217728;
  localparam logic [RAD_W-1:0] RAD_ONE = RAD_W'(1) << 56;

  // atan(2^-i), full turn is 2^32
  localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam int ATAN_SH = 32 - ANGLE_BITS;
  localparam logic [32:0] ATAN_RND = (33'd1 << ATAN_SH) >> 1;
  localparam int OUT_RSH = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
  localparam int OUT_LSH = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam logic [63:0] OUT_RND = (64'd1 << OUT_RSH) >> 1;
  localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  // sideband carried alongside the square root
  typedef struct packed {
    logic                   lock;
    logic signed [15:0]     plock;
    logic signed [SP_W-1:0] sp;
  } sq_side_t;

  // rounded arctangent step at the accumulator width
  function automatic logic [ANGLE_BITS-1:0] atan_step(input logic [4:0] idx);
    logic [32:0] a;
    a = {1'b0, ATAN_TURN32[idx]} + ATAN_RND;
    a = a >> ATAN_SH;
    return a[ANGLE_BITS-1:0];
  endfunction

  // accumulator to 16-bit binary angle, round half up and wrap
  function automatic logic [15:0] to_out16(input logic [ANGLE_BITS-1:0] z);
    logic [63:0] t;
    t = ((64'(z) + OUT_RND) >> OUT_RSH) << OUT_LSH;
    return t[15:0];
  endfunction

endpackage

>>> rtl/quaternion_to_euler_angles_top.sv
// quaternion to heading/pitch/bank pipeline, top level
// depends on qte_pkg, qte_cordic, qte_isqrt and assert_macros.svh
//
// Accepts one quaternion transaction per clock while stall_o is low and returns
// one set of euler angles per transaction, in order. The longest path is:
// products, sin(pitch), its square, a 29-stage square root for cos(pitch) and
// then the pitch cordic; heading and bank cordics run beside the square root
// and wait in a delay line. The whole pipeline holds while a finished result
// is stalled at the output; otherwise it moves every cycle.
// Angles are 16-bit binary angles, 32768 = pi. No configuration, no state.
module quaternion_to_euler_angles_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic               mode_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] heading_o,
  output logic signed [15:0] pitch_angle_o,
  output logic signed [15:0] bank_o,
  output logic               gimbal_lock_o
);
  import qte_pkg::*;

  `include "assert_macros.svh"

  typedef struct packed {
    logic [15:0] heading;
    logic [15:0] bank;
  } hb_t;

  typedef struct packed {
    logic               lock;
    logic signed [15:0] plock;
  } lk_t;

  logic en;
  logic [PIPE_LAT-1:0] vld_q;

  // pipeline advance, frozen only by a stalled result
  assign en      = !(vld_q[PIPE_LAT-1] && stall_i);
  assign stall_o = !en;
  assign valid_o = vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], valid_i};
    end
  end

  // stage 1: conjugate for mode 1, then the nine component products (no w*w)
  logic signed [16:0] wn;
  logic signed [32:0] p_wx_q, p_wy_q, p_wz_q;
  logic signed [32:0] p_xz_q, p_yz_q, p_xy_q, p_xx_q, p_yy_q, p_zz_q;

  assign wn = mode_i ? -$signed({quat_w_i[15], quat_w_i}) : $signed({quat_w_i[15], quat_w_i});

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wx_q <= 33'(wn) * 33'(quat_x_i);
      p_wy_q <= 33'(wn) * 33'(quat_y_i);
      p_wz_q <= 33'(wn) * 33'(quat_z_i);
      p_xz_q <= 33'(quat_x_i) * 33'(quat_z_i);
      p_yz_q <= 33'(quat_y_i) * 33'(quat_z_i);
      p_xy_q <= 33'(quat_x_i) * 33'(quat_y_i);
      p_xx_q <= 33'(quat_x_i) * 33'(quat_x_i);
      p_yy_q <= 33'(quat_y_i) * 33'(quat_y_i);
      p_zz_q <= 33'(quat_z_i) * 33'(quat_z_i);
    end
  end

  // stage 2: sin(pitch) with saturation, lock test, atan2 arguments
  logic signed [34:0]     sp_raw;
  logic signed [SP_W-1:0] sp_d, sp_q;
  logic [SP_W-1:0]        mag_full;
  logic [28:0]            mag, mag_rnd;
  logic [14:0]            pr;
  logic                   lock_d, lock_q;
  logic signed [15:0]     plock_d, plock_q;
  logic signed [33:0]     hy_d, hx_d, by_d, bx_d;
  logic signed [33:0]     hy_q, hx_q, by_q, bx_q;

  always_comb begin
    sp_raw = (35'(p_wx_q) - 35'(p_yz_q)) <<< 1;
    if (sp_raw > 35'(SP_ONE)) begin
      sp_d = SP_ONE;
    end else if (sp_raw < -35'(SP_ONE)) begin
      sp_d = -SP_ONE;
    end else begin
      sp_d = sp_raw[SP_W-1:0];
    end
    mag_full = sp_d[SP_W-1] ? SP_W'(-sp_d) : SP_W'(sp_d);
    mag      = mag_full[28:0];
    lock_d   = mag > LOCK_LIMIT;
    mag_rnd  = mag + 29'd8192;
    pr       = mag_rnd[28:14];
    plock_d  = sp_d[SP_W-1] ? -$signed({1'b0, pr}) : $signed({1'b0, pr});
    if (lock_d) begin
      hy_d = 34'(p_wy_q) - 34'(p_xz_q);
      hx_d = HALF_Q28 - 34'(p_yy_q) - 34'(p_zz_q);
    end else begin
      hy_d = 34'(p_xz_q) + 34'(p_wy_q);
      hx_d = HALF_Q28 - 34'(p_xx_q) - 34'(p_yy_q);
    end
    by_d = 34'(p_xy_q) + 34'(p_wz_q);
    bx_d = HALF_Q28 - 34'(p_xx_q) - 34'(p_zz_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_q    <= sp_d;
      lock_q  <= lock_d;
      plock_q <= plock_d;
      hy_q    <= hy_d;
      hx_q    <= hx_d;
      by_q    <= by_d;
      bx_q    <= bx_d;
    end
  end

  // heading and bank cordics
  logic [15:0] head_ang, bank_ang;

  qte_cordic u_head (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (XW'(hx_q)),
    .y_i     (XW'(hy_q)),
    .angle_o (head_ang)
  );

  qte_cordic u_bank (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (XW'(bx_q)),
    .y_i     (XW'(by_q)),
    .angle_o (bank_ang)
  );

  // stage 3: square of sin(pitch)
  logic [59:0]      spsq_full;
  logic [RAD_W-1:0] spsq_q;
  sq_side_t         side3_q;

  assign spsq_full = 60'(sp_q) * 60'(sp_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      spsq_q  <= spsq_full[RAD_W-1:0];
      side3_q <= '{lock: lock_q, plock: plock_q, sp: sp_q};
    end
  end

  // cos(pitch) = sqrt(1 - sp^2), then pitch = atan2(sp, cos)
  logic [ROOT_W-1:0]    root;
  sq_side_t             side_sq;
  logic [15:0]          pitch_ang;
  logic signed [XW-1:0] px, py;

  qte_isqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (RAD_ONE - spsq_q),
    .side_i (side3_q),
    .root_o (root),
    .side_o (side_sq)
  );

  assign px = $signed(XW'(root));
  assign py = XW'(side_sq.sp);

  qte_cordic u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (px),
    .y_i     (py),
    .angle_o (pitch_ang)
  );

  // delay lines aligning heading/bank and lock data with the pitch result
  hb_t hb_dly_q [HB_DLY];
  lk_t lk_dly_q [CORDIC_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hb_dly_q[0] <= '{heading: head_ang, bank: bank_ang};
      for (int i = 1; i < HB_DLY; i++) begin
        hb_dly_q[i] <= hb_dly_q[i-1];
      end
      lk_dly_q[0] <= '{lock: side_sq.lock, plock: side_sq.plock};
      for (int i = 1; i < CORDIC_LAT; i++) begin
        lk_dly_q[i] <= lk_dly_q[i-1];
      end
    end
  end

  // output register, gimbal-lock override
  logic signed [15:0] heading_q, pitch_q, bank_q;
  logic               glock_q;
  hb_t                hb_last;
  lk_t                lk_last;

  assign hb_last = hb_dly_q[HB_DLY-1];
  assign lk_last = lk_dly_q[CORDIC_LAT-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      heading_q <= hb_last.heading;
      pitch_q   <= lk_last.lock ? lk_last.plock : pitch_ang;
      bank_q    <= lk_last.lock ? 16'sd0 : hb_last.bank;
      glock_q   <= lk_last.lock;
    end
  end

  assign heading_o     = heading_q;
  assign pitch_angle_o = pitch_q;
  assign bank_o        = bank_q;
  assign gimbal_lock_o = glock_q;

  // checks on pipeline control and result consistency
  `QTE_ASSERT_NXT(a_accept_enters, clk_i, rst_ni, valid_i && !stall_o, vld_q[0])
  `QTE_ASSERT_NXT(a_freeze_holds, clk_i, rst_ni, !en, $stable(vld_q))
  `QTE_ASSERT_IMP(a_lock_bank_zero, clk_i, rst_ni, valid_o && gimbal_lock_o, bank_o == 16'sd0)
  `QTE_ASSERT_IMP(a_pitch_range, clk_i, rst_ni, valid_o,
                  (pitch_angle_o <= 16'sd16384) && (pitch_angle_o >= -16'sd16384))

endmodule

>>> rtl/qte_cordic.sv
// pipelined vectoring cordic atan2, one transaction per cycle while en_i is high
// depends on qte_pkg
module qte_cordic (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [qte_pkg::XW-1:0] x_i,
  input  logic signed [qte_pkg::XW-1:0] y_i,
  output logic [15:0]                  angle_o
);
  import qte_pkg::*;

  logic signed [XW-1:0]   x_q [CORDIC_STAGES+1];
  logic signed [XW-1:0]   y_q [CORDIC_STAGES+1];
  logic [ANGLE_BITS-1:0]  z_q [CORDIC_STAGES+1];
  logic                   zero_q [CORDIC_STAGES+1];
  logic [15:0]            angle_q;

  // prerotation into the right half-plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i[XW-1]) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= HALF_TURN;
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][XW-1]) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + atan_step(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - atan_step(5'(i));
        end
      end
    end
  end

  // output scaling, zero vector gives angle zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= zero_q[CORDIC_STAGES] ? 16'd0 : to_out16(z_q[CORDIC_STAGES]);
    end
  end

  assign angle_o = angle_q;

endmodule

>>> rtl/qte_isqrt.sv
// pipelined integer square root, one result bit per stage
// depends on qte_pkg (widths and sideband type)
module qte_isqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [qte_pkg::RAD_W-1:0]    rad_i,
  input  qte_pkg::sq_side_t            side_i,
  output logic [qte_pkg::ROOT_W-1:0]   root_o,
  output qte_pkg::sq_side_t            side_o
);
  import qte_pkg::*;

  logic [SQ_NW-1:0] n_q   [SQRT_STAGES];
  logic [SQ_NW-1:0] res_q [SQRT_STAGES];
  sq_side_t         side_q [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_bit
    localparam logic [SQ_NW-1:0] BIT = SQ_NW'(1) << (2 * (SQRT_STAGES - 1 - k));
    logic [SQ_NW-1:0] n_p;
    logic [SQ_NW-1:0] r_p;
    logic [SQ_NW-1:0] trial;
    sq_side_t         s_p;

    if (k == 0) begin : g_first
      assign n_p = SQ_NW'(rad_i);
      assign r_p = '0;
      assign s_p = side_i;
    end else begin : g_next
      assign n_p = n_q[k-1];
      assign r_p = res_q[k-1];
      assign s_p = side_q[k-1];
    end

    assign trial = r_p + BIT;

    // restoring step: keep the bit when the remainder covers the trial
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[k] <= s_p;
        if (n_p >= trial) begin
          n_q[k]   <= n_p - trial;
          res_q[k] <= (r_p >> 1) + BIT;
        end else begin
          n_q[k]   <= n_p;
          res_q[k] <= r_p >> 1;
        end
      end
    end
  end

  assign root_o = res_q[SQRT_STAGES-1][ROOT_W-1:0];
  assign side_o = side_q[SQRT_STAGES-1];

endmodule

>>> tb/testbench.sv
// testbench for quaternion_to_euler_angles_top: directed table then random quaternions
// depends on qte_pkg and the rtl top level; predicts angle sets from its own model or takes them from a typed row
`timescale 1ns / 1ps

module testbench;
  import qte_pkg::*;

  localparam int NUM_RANDOM  = 1330;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 2 * PIPE_LAT;

  typedef struct {
    logic               mode;
    logic signed [15:0] w, x, y, z;
    logic               typed;   // expected angles given in the row
    logic signed [15:0] heading, pitch, bank;
    logic               lock;
  } quat_row_t;

  typedef struct {
    logic signed [15:0] heading, pitch, bank;
    logic               lock;
  } euler_t;

  logic               clk_i, rst_ni;
  logic               valid_i, stall_o, mode_i;
  logic signed [15:0] quat_w_i, quat_x_i, quat_y_i, quat_z_i;
  logic               valid_o, stall_i;
  logic signed [15:0] heading_o, pitch_angle_o, bank_o;
  logic               gimbal_lock_o;

  quat_row_t stim_rows[$];
  euler_t    angles_pending[$];
  int        sent_count, phase, errors, cycles;
  bit        all_sent;

  quaternion_to_euler_angles_top dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // integer square root, floor
  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // vectoring atan2 as a 16-bit binary angle
  function automatic logic [15:0] binary_atan2(input longint ya, input longint xa);
    logic [63:0] mask, acc, stp, t;
    longint xs, ys;
    int d;
    mask = (64'd1 << ANGLE_BITS) - 1;
    acc = 0;
    if (xa == 0 && ya == 0) return 16'd0;
    if (xa < 0) begin
      xa = -xa;
      ya = -ya;
      acc = 64'd1 << (ANGLE_BITS - 1);
    end
    d = 32 - ANGLE_BITS;
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
      xs = xa >>> i;
      ys = ya >>> i;
      stp = (d == 0) ? 64'(ATAN_TURN32[i]) : (64'(ATAN_TURN32[i]) + (64'd1 << (d - 1))) >> d;
      if (ya >= 0) begin
        xa = xa + ys;
        ya = ya - xs;
        acc = (acc + stp) & mask;
      end else begin
        xa = xa - ys;
        ya = ya + xs;
        acc = (acc - stp) & mask;
      end
    end
    if (ANGLE_BITS > 16) t = (acc + (64'd1 << (ANGLE_BITS - 17))) >> (ANGLE_BITS - 16);
    else t = acc << (16 - ANGLE_BITS);
    return t[15:0];
  endfunction

  // heading, pitch and bank of one quaternion
  function automatic euler_t quat_to_euler(input quat_row_t r);
    euler_t e;
    longint w, x, y, z, sp, mag, p, half;
    w = r.w; x = r.x; y = r.y; z = r.z;
    half = longint'(1) << 27;
    if (r.mode) w = -w;
    sp = -2 * (y * z - w * x);
    if (sp > (longint'(1) << 28)) sp = longint'(1) << 28;
    if (sp < -(longint'(1) << 28)) sp = -(longint'(1) << 28);
    mag = (sp < 0) ? -sp : sp;
    if (mag > longint'(LOCK_LIMIT)) begin
      p = (mag + (longint'(1) << 13)) >>> 14;
      if (sp < 0) p = -p;
      e.heading = binary_atan2(w * y - x * z, half - y * y - z * z);
      e.pitch = p[15:0];
      e.bank = 16'sd0;
      e.lock = 1'b1;
    end else begin
      e.heading = binary_atan2(x * z + w * y, half - x * x - y * y);
      e.pitch = binary_atan2(sp, longint'(floor_root((64'd1 << 56) - 64'(sp * sp))));
      e.bank = binary_atan2(x * y + w * z, half - x * x - z * z);
      e.lock = 1'b0;
    end
    return e;
  endfunction

  function automatic quat_row_t mk_row(input logic m, input int w, x, y, z);
    quat_row_t r;
    r.mode = m; r.w = w; r.x = x; r.y = y; r.z = z;
    r.typed = 1'b0; r.heading = 0; r.pitch = 0; r.bank = 0; r.lock = 0;
    return r;
  endfunction

  function automatic quat_row_t mk_typed(input logic m, input int w, x, y, z,
                                         input int hd, pt, bk, input logic lk);
    quat_row_t r;
    r = mk_row(m, w, x, y, z);
    r.typed = 1'b1; r.heading = hd; r.pitch = pt; r.bank = bk; r.lock = lk;
    return r;
  endfunction

  // random unit quaternion, scaled to q1.14
  function automatic quat_row_t unit_quat();
    real a, b, c, d, n;
    a = real'(int'($urandom_range(0, 65536)) - 32768);
    b = real'(int'($urandom_range(0, 65536)) - 32768);
    c = real'(int'($urandom_range(0, 65536)) - 32768);
    d = real'(int'($urandom_range(0, 65536)) - 32768);
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) return mk_row($urandom_range(0, 1), 16384, 0, 0, 0);
    return mk_row($urandom_range(0, 1), $rtoi(a / n * 16384.0), $rtoi(b / n * 16384.0),
                  $rtoi(c / n * 16384.0), $rtoi(d / n * 16384.0));
  endfunction

  // stimulus table and random items
  initial begin
    int k, s, t;
    // identity, zero vector, saturated lock in both modes
    stim_rows.push_back(mk_typed(0, 16384, 0, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(mk_typed(1, 16384, 0, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(mk_typed(0, 0, 0, 0, 0, 0, 0, 0, 0));
    stim_rows.push_back(mk_typed(0, 16384, 16384, 0, 0, 0, 16384, 0, 1));
    stim_rows.push_back(mk_typed(1, 16384, 16384, 0, 0, 0, -16384, 0, 1));
    // field extremes
    stim_rows.push_back(mk_row(0, 32767, 32767, 32767, 32767));
    stim_rows.push_back(mk_row(1, -32768, -32768, -32768, -32768));
    stim_rows.push_back(mk_row(0, -32768, 32767, -32768, 32767));
    stim_rows.push_back(mk_row(1, 32767, -32768, 32767, -32768));
    stim_rows.push_back(mk_row(0, 0, -32768, 0, 0));
    // bank at pi, heading at pi
    stim_rows.push_back(mk_row(0, 0, 16384, 0, 0));
    stim_rows.push_back(mk_row(0, 0, 0, 0, 16384));
    stim_rows.push_back(mk_row(1, 0, 0, 16384, 0));
    // near the lock threshold on both sides
    stim_rows.push_back(mk_row(0, 11585, 11585, 0, 0));
    stim_rows.push_back(mk_row(0, 11584, 11584, 0, 0));
    stim_rows.push_back(mk_row(1, 11585, 11585, 100, -50));
    stim_rows.push_back(mk_row(0, 11585, -11585, 300, 200));
    stim_rows.push_back(mk_row(1, 8192, 8192, 8192, 8192));
    stim_rows.push_back(mk_row(0, 8192, -8192, 8192, -8192));
    stim_rows.push_back(mk_row(0, 14189, 0, 8192, 0));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      k = $urandom_range(0, 9);
      if (k < 6) begin
        stim_rows.push_back(unit_quat());
      end else if (k < 8) begin
        // around gimbal lock
        s = $urandom_range(0, 1) ? 11585 : -11585;
        t = $urandom_range(0, 1) ? s : -s;
        stim_rows.push_back(mk_row($urandom_range(0, 1), s + int'($urandom_range(0, 40)) - 20,
                                   t + int'($urandom_range(0, 40)) - 20,
                                   int'($urandom_range(0, 400)) - 200,
                                   int'($urandom_range(0, 400)) - 200));
      end else begin
        stim_rows.push_back(mk_row($urandom_range(0, 1), $urandom, $urandom, $urandom, $urandom));
      end
    end
  end

  // reset and sender
  initial begin
    quat_row_t nxt;
    bit idle;
    rst_ni = 1'b0; valid_i = 1'b0; mode_i = 1'b0;
    quat_w_i = 0; quat_x_i = 0; quat_y_i = 0; quat_z_i = 0;
    sent_count = 0; phase = 0; all_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!all_sent) begin
      @(posedge clk_i);
      if (valid_i && !stall_o) begin
        nxt = stim_rows[sent_count];
        if (nxt.typed)
          angles_pending.push_back('{nxt.heading, nxt.pitch, nxt.bank, nxt.lock});
        else
          angles_pending.push_back(quat_to_euler(nxt));
        sent_count++;
        phase = sent_count * 4 / stim_rows.size();
      end
      if (!valid_i || !stall_o) begin
        idle = (phase == 1) ? ($urandom_range(0, 99) < 50) :
               (phase == 3) ? ($urandom_range(0, 99) < 11) : 1'b0;
        if (sent_count >= stim_rows.size()) begin
          valid_i <= 1'b0;
          all_sent = 1;
        end else if (idle) begin
          valid_i <= 1'b0;
        end else begin
          nxt = stim_rows[sent_count];
          valid_i <= 1'b1;
          mode_i <= nxt.mode;
          quat_w_i <= nxt.w; quat_x_i <= nxt.x; quat_y_i <= nxt.y; quat_z_i <= nxt.z;
        end
      end
    end
    while (angles_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (angles_pending.size() != 0) begin
      $error("expected angle sets left over: %0d", angles_pending.size());
      errors++;
    end
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // receiver stall
  initial stall_i = 1'b0;
  always @(posedge clk_i) begin
    stall_i <= (phase == 2) ? ($urandom_range(0, 99) < 50) :
               (phase == 3) ? ($urandom_range(0, 99) < 11) : 1'b0;
  end

  // compare each angle transaction with the oldest expectation
  initial errors = 0;
  always @(posedge clk_i) begin
    euler_t e;
    if (rst_ni && valid_o && !stall_i) begin
      if (angles_pending.size() == 0) begin
        $error("angle transaction with nothing expected");
        errors++;
      end else begin
        e = angles_pending.pop_front();
        if (heading_o !== e.heading) begin
          $error("heading: expected %0d, got %0d", e.heading, heading_o);
          errors++;
        end
        if (pitch_angle_o !== e.pitch) begin
          $error("pitch_angle: expected %0d, got %0d", e.pitch, pitch_angle_o);
          errors++;
        end
        if (bank_o !== e.bank) begin
          $error("bank: expected %0d, got %0d", e.bank, bank_o);
          errors++;
        end
        if (gimbal_lock_o !== e.lock) begin
          $error("gimbal_lock: expected %0d, got %0d", e.lock, gimbal_lock_o);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule
